// ===== rtl/assert_macros.svh =====
// Assertion macros for the parser RTL.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle property.
`define HRBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next.
`define HRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HRBP_ASSERT(lbl, prop, msg)
`define HRBP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/hrbp_pkg.sv =====
package hrbp_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;

  // Token classes
  localparam logic [2:0] TC_DELIM  = 3'd0;
  localparam logic [2:0] TC_METHOD = 3'd1;
  localparam logic [2:0] TC_URI    = 3'd2;
  localparam logic [2:0] TC_PNAME  = 3'd3;
  localparam logic [2:0] TC_PVALUE = 3'd4;
  localparam logic [2:0] TC_HNAME  = 3'd5;
  localparam logic [2:0] TC_HVALUE = 3'd6;
  localparam logic [2:0] TC_BODY   = 3'd7;

  // Status codes
  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  // Length value sub-phases
  localparam logic [1:0] LV_SKIP    = 2'd0;
  localparam logic [1:0] LV_SIGN    = 2'd1;
  localparam logic [1:0] LV_DIGITS  = 2'd2;
  localparam logic [1:0] LV_STOPPED = 2'd3;

  localparam logic [15:0] VER_MAX = 16'hFFFF;
  localparam logic [3:0]  CL_LEN  = 4'd14;
  localparam logic [2:0]  POST_LEN = 3'd4;

  typedef enum logic [23:0] {
    PH_METHOD_START = 24'd1 << 0,
    PH_METHOD       = 24'd1 << 1,
    PH_URI          = 24'd1 << 2,
    PH_PNAME_START  = 24'd1 << 3,
    PH_PNAME        = 24'd1 << 4,
    PH_PVALUE       = 24'd1 << 5,
    PH_H            = 24'd1 << 6,
    PH_T1           = 24'd1 << 7,
    PH_T2           = 24'd1 << 8,
    PH_P            = 24'd1 << 9,
    PH_SLASH        = 24'd1 << 10,
    PH_MAJ_START    = 24'd1 << 11,
    PH_MAJ          = 24'd1 << 12,
    PH_MIN_START    = 24'd1 << 13,
    PH_MIN          = 24'd1 << 14,
    PH_NL1          = 24'd1 << 15,
    PH_HLINE        = 24'd1 << 16,
    PH_LWS          = 24'd1 << 17,
    PH_HNAME        = 24'd1 << 18,
    PH_SPACE        = 24'd1 << 19,
    PH_HVALUE       = 24'd1 << 20,
    PH_NL2          = 24'd1 << 21,
    PH_NL3          = 24'd1 << 22,
    PH_BODY         = 24'd1 << 23
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } hrbp_in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  token_class;
    logic        item_start;
    logic [1:0]  status;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [31:0] body_length;
  } hrbp_out_t;

  // Character class flags for one byte
  typedef struct packed {
    logic is_ctl;
    logic is_token;
    logic is_num;
    logic is_space;   // blank or 9..13, as atoi skips
    logic is_blank;   // space or tab
  } hrbp_cls_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  done;
    logic [2:0]  method_match;
    logic        method_mismatch;
    logic        headers_seen;
    logic [3:0]  name_match_pos;
    logic        name_mismatch;
    logic        len_active;
    logic        len_found;
    logic [1:0]  len_vphase;
    logic        value_negative;
    logic [15:0] major_version;
    logic [15:0] minor_version;
  } hrbp_state_t;

  localparam hrbp_state_t STATE_RESET = '{
    phase:           PH_METHOD_START,
    done:            ST_PENDING,
    method_match:    3'd0,
    method_mismatch: 1'b0,
    headers_seen:    1'b0,
    name_match_pos:  4'd0,
    name_mismatch:   1'b0,
    len_active:      1'b0,
    len_found:       1'b0,
    len_vphase:      LV_SKIP,
    value_negative:  1'b0,
    major_version:   16'd0,
    minor_version:   16'd0
  };

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = "P";
      2'd1: ch = "O";
      2'd2: ch = "S";
      default: ch = "T";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:  ch = "C";
      4'd1:  ch = "o";
      4'd2:  ch = "n";
      4'd3:  ch = "t";
      4'd4:  ch = "e";
      4'd5:  ch = "n";
      4'd6:  ch = "t";
      4'd7:  ch = "-";
      4'd8:  ch = "L";
      4'd9:  ch = "e";
      4'd10: ch = "n";
      4'd11: ch = "g";
      4'd12: ch = "t";
      4'd13: ch = "h";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // Decimal accumulate, saturating at 65535
  function automatic logic [15:0] ver_acc(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
    return (n[19:16] != 4'd0) ? VER_MAX : n[15:0];
  endfunction

endpackage

// ===== rtl/http_request_byte_parser_core.sv =====
// Channel  Direction  Handshake          Beat
// in_      input      in_valid/in_stall   hrbp_in_t  (data_byte, restart)
// out_     output     out_valid/out_stall hrbp_out_t (byte, class, start, status, lengths)
//
// One byte per cycle sustained unless out_stall holds a full result register.
// An input register feeds the parse step, whose state updates as the result register loads.
// in_stall rises only when the input register holds a byte and the result register is
// full and stalled.
// rst_n is synchronous; it clears the parser to the start of a request.
`include "assert_macros.svh"

module http_request_byte_parser_core
  import hrbp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hrbp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output hrbp_out_t out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  hrbp_in_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  hrbp_out_t out_data_r;
  logic      adv;
  logic      in_acc;
  hrbp_cls_t cls;
  hrbp_out_t res;

  // Advance the staged byte whenever the result register is free or emptying
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;

    if (adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  hrbp_classify u_classify (
    .c_i   (s1_data_r.data_byte),
    .cls_o (cls)
  );

  hrbp_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .beat_i (s1_data_r),
    .cls_i  (cls),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_data;
    if (adv) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HRBP_ASSERT_NEXT(a_adv_loads_out, adv, out_valid_r, "advanced beat did not reach output")
  `HRBP_ASSERT_NEXT(a_s1_hold, s1_valid_r && !adv, s1_valid_r && $stable(s1_data_r), "staged beat lost while blocked")
  `HRBP_ASSERT(a_err_class, !out_valid_r || (out_data_r.status != ST_ERROR) || ((out_data_r.token_class == TC_DELIM) && !out_data_r.item_start), "error beat carries a token class")
  `HRBP_ASSERT(a_stall_cause, !in_stall || (out_valid_r && out_stall), "input stalled with output free")

endmodule

// ===== rtl/hrbp_classify.sv =====
module hrbp_classify
  import hrbp_pkg::*;
(
  input  logic [7:0] c_i,
  output hrbp_cls_t  cls_o
);

  logic is_sep;
  logic is_ctl;

  always_comb begin
    case (c_i)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: is_sep = 1'b1;
      default: is_sep = 1'b0;
    endcase
  end

  assign is_ctl          = (c_i <= 8'd31) || (c_i == 8'd127);
  assign cls_o.is_ctl    = is_ctl;
  assign cls_o.is_token  = !c_i[7] && !is_ctl && !is_sep;
  assign cls_o.is_num    = (c_i >= "0") && (c_i <= "9");
  assign cls_o.is_space  = (c_i == " ") || ((c_i >= 8'd9) && (c_i <= 8'd13));
  assign cls_o.is_blank  = (c_i == " ") || (c_i == 8'h09);

endmodule

// ===== rtl/hrbp_fsm.sv =====
module hrbp_fsm
  import hrbp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv_i,
  input  hrbp_in_t  beat_i,
  input  hrbp_cls_t cls_i,
  output hrbp_out_t res_o
);

  hrbp_state_t            st_r, st_nxt, cur;
  logic [LENGTH_BITS-1:0] len_r, len_nxt, cur_len;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, cur_cnt;

  logic [7:0]             c;
  logic [3:0]             d;
  logic [LENGTH_BITS+3:0] len_x10;
  logic [LENGTH_BITS-1:0] len_acc;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   m_ok;
  logic                   n_ok;
  logic                   nh_ok;

  logic [LENGTH_BITS-1:0] val_len;
  logic [1:0]             val_vph;
  logic                   val_neg;

  logic [2:0]             tc;
  logic                   start;
  logic [1:0]             sts;
  logic                   err;

  assign c = beat_i.data_byte;
  assign d = c[3:0];

  // Current state, cleared first on a restart beat
  always_comb begin
    if (beat_i.restart) begin
      cur     = STATE_RESET;
      cur_len = '0;
      cur_cnt = '0;
    end else begin
      cur     = st_r;
      cur_len = len_r;
      cur_cnt = cnt_r;
    end
  end

  // Saturate when the product spills above the length width
  assign len_x10 = {1'b0, cur_len, 3'b000} + {3'b000, cur_len, 1'b0} + (LENGTH_BITS+4)'(d);
  assign len_acc = (len_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1
                                                                : len_x10[LENGTH_BITS-1:0];
  assign cnt_inc = cur_cnt + LENGTH_BITS'(1);

  assign m_ok  = !cur.method_mismatch && (cur.method_match < POST_LEN) &&
                 (c == post_char(cur.method_match[1:0]));
  assign n_ok  = !cur.name_mismatch && (cur.name_match_pos < CL_LEN) &&
                 (c == cl_char(cur.name_match_pos));
  assign nh_ok = (c == cl_char(4'd0));

  // atoi-style step on the Content-Length value
  always_comb begin
    val_len = cur_len;
    val_vph = cur.len_vphase;
    val_neg = cur.value_negative;
    if (cur.len_active) begin
      case (cur.len_vphase)
        LV_SKIP: begin
          if (cls_i.is_space) begin
            val_vph = LV_SKIP;
          end else if (c == "+") begin
            val_vph = LV_SIGN;
          end else if (c == "-") begin
            val_vph = LV_SIGN;
            val_neg = 1'b1;
          end else if (cls_i.is_num) begin
            val_len = len_acc;
            val_vph = LV_DIGITS;
          end else begin
            val_vph = LV_STOPPED;
          end
        end
        LV_SIGN, LV_DIGITS: begin
          if (cls_i.is_num) begin
            val_len = len_acc;
            val_vph = LV_DIGITS;
          end else begin
            val_vph = LV_STOPPED;
          end
        end
        default: val_vph = LV_STOPPED;
      endcase
    end
  end

  always_comb begin
    st_nxt  = cur;
    len_nxt = cur_len;
    cnt_nxt = cur_cnt;
    tc      = TC_DELIM;
    start   = 1'b0;
    sts     = ST_PENDING;
    err     = 1'b0;

    if (cur.done != ST_PENDING) begin
      sts = cur.done;
    end else begin
      case (cur.phase)
        PH_METHOD_START: begin
          if (!cls_i.is_token) begin
            err = 1'b1;
          end else begin
            if (m_ok) st_nxt.method_match = cur.method_match + 3'd1;
            else st_nxt.method_mismatch = 1'b1;
            tc = TC_METHOD;
            st_nxt.phase = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (c == " ") begin
            st_nxt.phase = PH_URI;
          end else if (!cls_i.is_token) begin
            err = 1'b1;
          end else begin
            if (m_ok) st_nxt.method_match = cur.method_match + 3'd1;
            else st_nxt.method_mismatch = 1'b1;
            tc = TC_METHOD;
          end
        end
        PH_URI: begin
          if (c == " ") st_nxt.phase = PH_H;
          else if (c == "?") st_nxt.phase = PH_PNAME_START;
          else if (cls_i.is_ctl) err = 1'b1;
          else tc = TC_URI;
        end
        PH_PNAME_START: begin
          if (!cls_i.is_token) begin
            err = 1'b1;
          end else begin
            tc = TC_PNAME;
            start = 1'b1;
            st_nxt.phase = PH_PNAME;
          end
        end
        PH_PNAME: begin
          if (c == "=") st_nxt.phase = PH_PVALUE;
          else if (!cls_i.is_token) err = 1'b1;
          else tc = TC_PNAME;
        end
        PH_PVALUE: begin
          if (c == "&") st_nxt.phase = PH_PNAME_START;
          else if (c == " ") st_nxt.phase = PH_H;
          else if (cls_i.is_ctl) err = 1'b1;
          else tc = TC_PVALUE;
        end
        PH_H: begin
          if (c == "H") st_nxt.phase = PH_T1;
          else err = 1'b1;
        end
        PH_T1: begin
          if (c == "T") st_nxt.phase = PH_T2;
          else err = 1'b1;
        end
        PH_T2: begin
          if (c == "T") st_nxt.phase = PH_P;
          else err = 1'b1;
        end
        PH_P: begin
          if (c == "P") st_nxt.phase = PH_SLASH;
          else err = 1'b1;
        end
        PH_SLASH: begin
          if (c == "/") begin
            st_nxt.major_version = 16'd0;
            st_nxt.minor_version = 16'd0;
            st_nxt.phase = PH_MAJ_START;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAJ_START: begin
          if (cls_i.is_num) begin
            st_nxt.major_version = ver_acc(cur.major_version, d);
            st_nxt.phase = PH_MAJ;
          end else begin
            err = 1'b1;
          end
        end
        PH_MAJ: begin
          if (c == ".") st_nxt.phase = PH_MIN_START;
          else if (cls_i.is_num) st_nxt.major_version = ver_acc(cur.major_version, d);
          else err = 1'b1;
        end
        PH_MIN_START: begin
          if (cls_i.is_num) begin
            st_nxt.minor_version = ver_acc(cur.minor_version, d);
            st_nxt.phase = PH_MIN;
          end else begin
            err = 1'b1;
          end
        end
        PH_MIN: begin
          if (c == 8'h0D) st_nxt.phase = PH_NL1;
          else if (cls_i.is_num) st_nxt.minor_version = ver_acc(cur.minor_version, d);
          else err = 1'b1;
        end
        PH_NL1, PH_NL2: begin
          if (c == 8'h0A) st_nxt.phase = PH_HLINE;
          else err = 1'b1;
        end
        PH_HLINE: begin
          if (c == 8'h0D) begin
            st_nxt.phase = PH_NL3;
          end else if (cur.headers_seen && cls_i.is_blank) begin
            st_nxt.phase = PH_LWS;
          end else if (!cls_i.is_token) begin
            err = 1'b1;
          end else begin
            // open a new header entry and match its first character
            st_nxt.headers_seen   = 1'b1;
            st_nxt.len_active     = 1'b0;
            st_nxt.name_match_pos = nh_ok ? 4'd1 : 4'd0;
            st_nxt.name_mismatch  = !nh_ok;
            tc = TC_HNAME;
            start = 1'b1;
            st_nxt.phase = PH_HNAME;
          end
        end
        PH_LWS: begin
          if (c == 8'h0D) begin
            st_nxt.phase = PH_NL2;
          end else if (cls_i.is_blank) begin
            st_nxt.phase = PH_LWS;
          end else if (cls_i.is_ctl) begin
            err = 1'b1;
          end else begin
            len_nxt = val_len;
            st_nxt.len_vphase = val_vph;
            st_nxt.value_negative = val_neg;
            tc = TC_HVALUE;
            st_nxt.phase = PH_HVALUE;
          end
        end
        PH_HNAME: begin
          if (c == ":") begin
            if (!cur.name_mismatch && (cur.name_match_pos == CL_LEN) && !cur.len_found) begin
              st_nxt.len_found      = 1'b1;
              st_nxt.len_active     = 1'b1;
              st_nxt.len_vphase     = LV_SKIP;
              st_nxt.value_negative = 1'b0;
              len_nxt = '0;
            end
            st_nxt.phase = PH_SPACE;
          end else if (!cls_i.is_token) begin
            err = 1'b1;
          end else begin
            if (n_ok) st_nxt.name_match_pos = cur.name_match_pos + 4'd1;
            else st_nxt.name_mismatch = 1'b1;
            tc = TC_HNAME;
          end
        end
        PH_SPACE: begin
          if (c == " ") st_nxt.phase = PH_HVALUE;
          else err = 1'b1;
        end
        PH_HVALUE: begin
          if (c == 8'h0D) begin
            st_nxt.phase = PH_NL2;
          end else if (cls_i.is_ctl) begin
            err = 1'b1;
          end else begin
            len_nxt = val_len;
            st_nxt.len_vphase = val_vph;
            st_nxt.value_negative = val_neg;
            tc = TC_HVALUE;
          end
        end
        PH_NL3: begin
          if (c != 8'h0A) begin
            err = 1'b1;
          end else if ((cur.method_match == POST_LEN) && !cur.method_mismatch &&
                       (cur_len != '0)) begin
            if (cur.value_negative) err = 1'b1;
            else st_nxt.phase = PH_BODY;
          end else begin
            sts = ST_FINISHED;
          end
        end
        PH_BODY: begin
          tc = TC_BODY;
          cnt_nxt = cnt_inc;
          if (cnt_inc == cur_len) sts = ST_FINISHED;
        end
        default: err = 1'b1;
      endcase

      if (err) begin
        sts   = ST_ERROR;
        tc    = TC_DELIM;
        start = 1'b0;
      end
      st_nxt.done = sts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_RESET;
      len_r <= '0;
      cnt_r <= '0;
    end else if (adv_i) begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res_o.byte_out      = c;
  assign res_o.token_class   = tc;
  assign res_o.item_start    = start;
  assign res_o.status        = sts;
  assign res_o.version_major = st_nxt.major_version;
  assign res_o.version_minor = st_nxt.minor_version;
  assign res_o.body_length   = 32'(len_nxt);

endmodule
